### hdl/prl_pkg.sv
// Shared types, command and status codes for the positional record list.
// Depends on nothing; every other file imports it.
`default_nettype none
package prl_pkg;

    // list geometry
    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = 5;
    localparam int FW    = 4;

    // command codes
    localparam logic [2:0] CMD_ENQ    = 3'd0;
    localparam logic [2:0] CMD_DEQ    = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_SEARCH = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_POS   = 3'd4;

    // one stored record
    typedef struct packed {
        logic [31:0] name_key;
        logic [7:0]  career_code;
        logic [7:0]  subjects_passed;
        logic [9:0]  average_hundredths;
    } t_rec;

    // one write and one read port request
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_rec          wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_mem_req;

endpackage
`default_nettype wire

### hdl/positional_record_list.sv
// Top level of the positional record list: command sequencer around the record RAM.
// Depends on prl_pkg and prl_ram.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------------------
//  command   | start in, busy out          | i_cmd, i_position, i_name_key, i_career_code,
//            |                             | i_subjects_passed, i_average_hundredths
//  result    | o_done strobe, one cycle    | o_status, o_found_index, o_out_*, o_entry_count,
//            |                             | o_is_empty, o_is_full
//
// One result follows each word taken (start high, busy low). Insert and enqueue move the
// entries at and above the position up one place, then write the record; delete moves the
// entries above it down one place (the last entry needs no move); search reads from index 0
// to the first match or the count; dequeue and read fetch one entry. One RAM read per cycle.
// Synchronous active-low reset clears the count; RAM contents are undefined until written.
// The receiver cannot stall; a new word may be taken in the cycle its result is shown.
`default_nettype none
module positional_record_list
    import prl_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [2:0]    i_cmd,
    input  wire logic [PW-1:0] i_position,
    input  wire logic [31:0]   i_name_key,
    input  wire logic [7:0]    i_career_code,
    input  wire logic [7:0]    i_subjects_passed,
    input  wire logic [9:0]    i_average_hundredths,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [FW-1:0]      o_found_index,
    output logic [31:0]        o_out_name_key,
    output logic [7:0]         o_out_career_code,
    output logic [7:0]         o_out_subjects_passed,
    output logic [9:0]         o_out_average_hundredths,
    output logic [CW-1:0]      o_entry_count,
    output logic               o_is_empty,
    output logic               o_is_full
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_UP    = 5'b00010,
        S_DOWN  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FETCH = 5'b10000
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_done, n_done;
    logic           r_more, n_more;
    logic           r_pend, n_pend;
    logic [CW-1:0]  r_ptr, n_ptr;
    logic [CW-1:0]  r_pend_addr, n_pend_addr;
    logic [2:0]     r_cmd, n_cmd;
    logic [CW-1:0]  r_pos, n_pos;
    t_rec           r_rec, n_rec;
    logic [2:0]     r_status, n_status;
    logic [FW-1:0]  r_found, n_found;
    t_rec           r_out, n_out;

    t_mem_req       w_req;
    t_rec           w_rdata;
    logic           w_last;
    logic [CW-1:0]  w_in_pos;

    prl_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // last read of the walk
    always_comb begin
        case (r_state)
            S_UP:           w_last = (r_ptr == r_pos);
            S_DOWN, S_SCAN: w_last = (r_ptr == CW'(r_count - 1'b1));
            default:        w_last = 1'b1;
        endcase
    end

    // enqueue always targets the head
    assign w_in_pos = (i_cmd == CMD_ENQ) ? '0 : CW'(i_position);

    // sequence one command
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_done      = 1'b0;
        n_more      = r_more;
        n_pend      = 1'b0;
        n_ptr       = r_ptr;
        n_pend_addr = r_pend_addr;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_rec       = r_rec;
        n_status    = r_status;
        n_found     = r_found;
        n_out       = r_out;
        w_req       = '0;

        // issue the next read of the walk
        if ((r_state != S_IDLE) && r_more) begin
            w_req.re    = 1'b1;
            w_req.raddr = r_ptr[AW-1:0];
            n_pend      = 1'b1;
            n_pend_addr = r_ptr;
            if (w_last) begin
                n_more = 1'b0;
            end else if (r_state == S_UP) begin
                n_ptr = CW'(r_ptr - 1'b1);
            end else begin
                n_ptr = CW'(r_ptr + 1'b1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_pos   = w_in_pos;
                    n_rec   = '{name_key: i_name_key, career_code: i_career_code,
                                subjects_passed: i_subjects_passed,
                                average_hundredths: i_average_hundredths};
                    n_found = '0;
                    n_out   = '0;
                    case (i_cmd)
                        CMD_ENQ, CMD_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else if (w_in_pos > r_count) begin
                                n_status = ST_BAD_POS;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_UP;
                                n_ptr   = CW'(r_count - 1'b1);
                                n_more  = (w_in_pos != r_count);
                            end
                        end
                        CMD_DEQ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_FETCH;
                                n_ptr   = CW'(r_count - 1'b1);
                                n_more  = 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else if (w_in_pos >= r_count) begin
                                n_status = ST_BAD_POS;
                                n_done   = 1'b1;
                            end else if (w_in_pos == CW'(r_count - 1'b1)) begin
                                n_count  = CW'(r_count - 1'b1);
                                n_status = ST_OK;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_DOWN;
                                n_ptr   = CW'(w_in_pos + 1'b1);
                                n_more  = 1'b1;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                                n_ptr   = '0;
                                n_more  = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            if (w_in_pos >= r_count) begin
                                n_status = ST_BAD_POS;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_FETCH;
                                n_ptr   = w_in_pos;
                                n_more  = 1'b1;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end

            // move entries up one place, then drop the new record in
            S_UP: begin
                if (r_pend) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = AW'(r_pend_addr + 1'b1);
                    w_req.wdata = w_rdata;
                end else if (!r_more) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_pos[AW-1:0];
                    w_req.wdata = r_rec;
                    n_count     = CW'(r_count + 1'b1);
                    n_status    = ST_OK;
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            // move entries down one place over the deleted one
            S_DOWN: begin
                if (r_pend) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = AW'(r_pend_addr - 1'b1);
                    w_req.wdata = w_rdata;
                end else if (!r_more) begin
                    n_count  = CW'(r_count - 1'b1);
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            // compare each returned key, stop at the first hit
            S_SCAN: begin
                if (r_pend && (w_rdata.name_key == r_rec.name_key)) begin
                    n_found  = FW'(r_pend_addr);
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    n_more   = 1'b0;
                    n_state  = S_IDLE;
                end else if (r_pend && !r_more) begin
                    n_status = ST_NOT_FOUND;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            // single entry for dequeue or read
            S_FETCH: begin
                if (r_pend) begin
                    n_out    = w_rdata;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                    if (r_cmd == CMD_DEQ) begin
                        n_count = CW'(r_count - 1'b1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
                n_more  = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_more  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_more  <= n_more;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_pend_addr <= n_pend_addr;
        r_cmd       <= n_cmd;
        r_pos       <= n_pos;
        r_rec       <= n_rec;
        r_status    <= n_status;
        r_found     <= n_found;
        r_out       <= n_out;
    end

    // drive the result word
    assign busy                     = (r_state != S_IDLE);
    assign o_done                   = r_done;
    assign o_status                 = r_status;
    assign o_found_index            = r_found;
    assign o_out_name_key           = r_out.name_key;
    assign o_out_career_code        = r_out.career_code;
    assign o_out_subjects_passed    = r_out.subjects_passed;
    assign o_out_average_hundredths = r_out.average_hundredths;
    assign o_entry_count            = r_count;
    assign o_is_empty               = (r_count == '0);
    assign o_is_full                = (r_count == CW'(DEPTH));

endmodule
`default_nettype wire

### hdl/prl_ram.sv
// Record store: simple dual-port synchronous RAM, one write and one read per cycle.
// Read data is registered: it appears in the cycle after the read. Depends on prl_pkg.
`default_nettype none
module prl_ram
    import prl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_rec          o_rdata
);

    t_rec r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule
`default_nettype wire

### dv/positional_record_list_checker.sv
// Checker for the positional record list: watches the command and result channels,
// predicts every result from its own copy of the list and compares field by field.
// Depends on prl_pkg.
`default_nettype none
module positional_record_list_checker
    import prl_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_busy,
    input  wire logic [2:0]    i_cmd,
    input  wire logic [PW-1:0] i_position,
    input  wire logic [31:0]   i_name_key,
    input  wire logic [7:0]    i_career_code,
    input  wire logic [7:0]    i_subjects_passed,
    input  wire logic [9:0]    i_average_hundredths,
    input  wire logic          i_done,
    input  wire logic [2:0]    i_status,
    input  wire logic [FW-1:0] i_found_index,
    input  wire logic [31:0]   i_out_name_key,
    input  wire logic [7:0]    i_out_career_code,
    input  wire logic [7:0]    i_out_subjects_passed,
    input  wire logic [9:0]    i_out_average_hundredths,
    input  wire logic [CW-1:0] i_entry_count,
    input  wire logic          i_is_empty,
    input  wire logic          i_is_full,
    output int                 o_error_count,
    output int                 o_pending,
    output int                 o_checked
);

    // one predicted result word
    typedef struct packed {
        logic [2:0]    status;
        logic [FW-1:0] found_index;
        t_rec          rec;
        logic [CW-1:0] entry_count;
        logic          is_empty;
        logic          is_full;
    } t_list_result;

    localparam int MAX_PRINTED = 40;

    t_rec         record_store [DEPTH];
    int           held_entries;
    t_list_result expected_results [$];
    t_list_result want;
    int           error_total;
    int           checked_total;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        o_checked     = 0;
        error_total   = 0;
        checked_total = 0;
        held_entries  = 0;
    end

    // print one line per mismatch, up to a cap, and count every one
    task automatic report_mismatch(input string msg);
        error_total++;
        if (error_total <= MAX_PRINTED) begin
            $display("[%0t] checker: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s got 0x%0h, predicted 0x%0h", field, got, exp_val));
        end
    endtask

    // open a slot at the given position and store the record there
    function automatic logic [2:0] insert_record(input int at, input t_rec rec);
        int idx;
        if (held_entries >= DEPTH) begin
            return ST_FULL;
        end
        if (at > held_entries) begin
            return ST_BAD_POS;
        end
        for (idx = held_entries; idx > at; idx--) begin
            record_store[idx] = record_store[idx - 1];
        end
        record_store[at] = rec;
        held_entries++;
        return ST_OK;
    endfunction

    // apply one command to the shadow list and return the result it gives
    function automatic t_list_result apply_list_command(input logic [2:0] cmd,
                                                        input logic [PW-1:0] pos,
                                                        input t_rec rec);
        t_list_result res;
        int           idx;
        int           at;
        bit           hit;
        res = '0;
        at  = int'(pos);
        hit = 1'b0;
        case (cmd)
            CMD_ENQ: begin
                res.status = insert_record(0, rec);
            end
            CMD_DEQ: begin
                if (held_entries == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    held_entries--;
                    res.rec = record_store[held_entries];
                end
            end
            CMD_INSERT: begin
                res.status = insert_record(at, rec);
            end
            CMD_DELETE: begin
                if (held_entries == 0) begin
                    res.status = ST_EMPTY;
                end else if (at >= held_entries) begin
                    res.status = ST_BAD_POS;
                end else begin
                    for (idx = at; idx + 1 < held_entries; idx++) begin
                        record_store[idx] = record_store[idx + 1];
                    end
                    held_entries--;
                end
            end
            CMD_SEARCH: begin
                res.status = ST_NOT_FOUND;
                for (idx = 0; idx < held_entries && !hit; idx++) begin
                    if (record_store[idx].name_key == rec.name_key) begin
                        hit             = 1'b1;
                        res.status      = ST_OK;
                        res.found_index = idx[FW-1:0];
                    end
                end
            end
            CMD_READ: begin
                if (at >= held_entries) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res.rec = record_store[at];
                end
            end
            default: begin
                // spare codes do nothing and report ok
                res.status = ST_OK;
            end
        endcase
        res.entry_count = held_entries[CW-1:0];
        res.is_empty    = (held_entries == 0);
        res.is_full     = (held_entries >= DEPTH);
        return res;
    endfunction

    // compare results first: a new word may be taken in the cycle a result shows
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_entries = 0;
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with no command outstanding");
                end else begin
                    want = expected_results.pop_front();
                    checked_total++;
                    check_field("status", 32'(i_status), 32'(want.status));
                    check_field("found_index", 32'(i_found_index),
                                32'(want.found_index));
                    check_field("out_name_key", i_out_name_key, want.rec.name_key);
                    check_field("out_career_code", 32'(i_out_career_code),
                                32'(want.rec.career_code));
                    check_field("out_subjects_passed", 32'(i_out_subjects_passed),
                                32'(want.rec.subjects_passed));
                    check_field("out_average_hundredths", 32'(i_out_average_hundredths),
                                32'(want.rec.average_hundredths));
                    check_field("entry_count", 32'(i_entry_count),
                                32'(want.entry_count));
                    check_field("is_empty", 32'(i_is_empty), 32'(want.is_empty));
                    check_field("is_full", 32'(i_is_full), 32'(want.is_full));
                end
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(apply_list_command(i_cmd, i_position,
                    '{name_key: i_name_key, career_code: i_career_code,
                      subjects_passed: i_subjects_passed,
                      average_hundredths: i_average_hundredths}));
            end
        end
        o_error_count <= error_total;
        o_pending     <= expected_results.size();
        o_checked     <= checked_total;
    end

endmodule
`default_nettype wire

### dv/positional_record_list_tb.sv
// Testbench top for the positional record list: clock, reset, command stimulus and verdict.
// Depends on prl_pkg, positional_record_list and positional_record_list_checker.
`default_nettype none
module positional_record_list_tb;
    import prl_pkg::*;

    // spare command codes the block must treat as no operation
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS = 1650;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 40;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1000;

    logic          i_clk                = 1'b0;
    logic          i_rst_n              = 1'b0;
    logic          start                = 1'b0;
    logic [2:0]    i_cmd                = '0;
    logic [PW-1:0] i_position           = '0;
    logic [31:0]   i_name_key           = '0;
    logic [7:0]    i_career_code        = '0;
    logic [7:0]    i_subjects_passed    = '0;
    logic [9:0]    i_average_hundredths = '0;

    logic          busy;
    logic          o_done;
    logic [2:0]    o_status;
    logic [FW-1:0] o_found_index;
    logic [31:0]   o_out_name_key;
    logic [7:0]    o_out_career_code;
    logic [7:0]    o_out_subjects_passed;
    logic [9:0]    o_out_average_hundredths;
    logic [CW-1:0] o_entry_count;
    logic          o_is_empty;
    logic          o_is_full;

    int            error_count;
    int            pending_results;
    int            checked_results;
    int            cycle_count = 0;
    int            words_sent  = 0;
    int            words_by_cmd [8];
    int            last_count  = 0;
    logic [31:0]   key_pool [8];

    always #4 i_clk = ~i_clk;

    positional_record_list u_dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .start                    (start),
        .busy                     (busy),
        .i_cmd                    (i_cmd),
        .i_position               (i_position),
        .i_name_key               (i_name_key),
        .i_career_code            (i_career_code),
        .i_subjects_passed        (i_subjects_passed),
        .i_average_hundredths     (i_average_hundredths),
        .o_done                   (o_done),
        .o_status                 (o_status),
        .o_found_index            (o_found_index),
        .o_out_name_key           (o_out_name_key),
        .o_out_career_code        (o_out_career_code),
        .o_out_subjects_passed    (o_out_subjects_passed),
        .o_out_average_hundredths (o_out_average_hundredths),
        .o_entry_count            (o_entry_count),
        .o_is_empty               (o_is_empty),
        .o_is_full                (o_is_full)
    );

    positional_record_list_checker u_checker (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_start                  (start),
        .i_busy                   (busy),
        .i_cmd                    (i_cmd),
        .i_position               (i_position),
        .i_name_key               (i_name_key),
        .i_career_code            (i_career_code),
        .i_subjects_passed        (i_subjects_passed),
        .i_average_hundredths     (i_average_hundredths),
        .i_done                   (o_done),
        .i_status                 (o_status),
        .i_found_index            (o_found_index),
        .i_out_name_key           (o_out_name_key),
        .i_out_career_code        (o_out_career_code),
        .i_out_subjects_passed    (o_out_subjects_passed),
        .i_out_average_hundredths (o_out_average_hundredths),
        .i_entry_count            (o_entry_count),
        .i_is_empty               (o_is_empty),
        .i_is_full                (o_is_full),
        .o_error_count            (error_count),
        .o_pending                (pending_results),
        .o_checked                (checked_results)
    );

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("positional_record_list: mismatch");
            $finish;
        end
    end

    // track the reported count to aim positions at the live part of the list
    always @(posedge i_clk) begin
        if (o_done) begin
            last_count <= int'(o_entry_count);
        end
    end

    // hold one command word until taken, then maybe idle a while
    task automatic send_word(input logic [2:0] cmd, input logic [PW-1:0] pos,
                             input logic [31:0] key, input logic [7:0] career,
                             input logic [7:0] subjects, input logic [9:0] avg);
        start                <= 1'b1;
        i_cmd                <= cmd;
        i_position           <= pos;
        i_name_key           <= key;
        i_career_code        <= career;
        i_subjects_passed    <= subjects;
        i_average_hundredths <= avg;
        do @(posedge i_clk); while (busy);
        words_sent++;
        words_by_cmd[cmd]++;
        if (!(words_sent >= QUIET_FIRST && words_sent < QUIET_LAST)
            && $urandom_range(0, 99) < 17) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        int          idx;
        int          phase_left;
        bit          filling;
        int          pick;
        logic [2:0]  cmd;
        logic [PW-1:0] pos;
        logic [31:0] key;
        logic [9:0]  avg;

        for (idx = 0; idx < 8; idx++) begin
            words_by_cmd[idx] = 0;
            key_pool[idx]     = $urandom;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list corners, spare codes, field extremes, range checks
        send_word(CMD_DEQ,      5'd0,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_DELETE,   5'd0,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_READ,     5'd0,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_SEARCH,   5'd0,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_SPARE_LO, 5'd31, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 10'd1023);
        send_word(CMD_SPARE_HI, 5'd0,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_INSERT,   5'd1,  32'h1111_1111, 8'h11, 8'h11, 10'd1);
        send_word(CMD_ENQ,      5'd0,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 10'd1023);
        send_word(CMD_INSERT,   5'd0,  32'h0000_0000, 8'h00, 8'h00, 10'd0);
        send_word(CMD_INSERT,   5'd2,  32'hA5A5_5A5A, 8'h5A, 8'hA5, 10'd1000);
        send_word(CMD_SEARCH,   5'd0,  32'hFFFF_FFFF, 8'h00, 8'h00, 10'd0);
        send_word(CMD_SEARCH,   5'd0,  32'h1234_5678, 8'h00, 8'h00, 10'd0);
        send_word(CMD_READ,     5'd1,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_READ,     5'd3,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_READ,     5'd31, 32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_DELETE,   5'd5,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_INSERT,   5'd31, 32'h2222_2222, 8'h22, 8'h22, 10'd2);
        send_word(CMD_DELETE,   5'd1,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_DEQ,      5'd0,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_DEQ,      5'd0,  32'h0,         8'h00, 8'h00, 10'd0);
        send_word(CMD_DEQ,      5'd0,  32'h0,         8'h00, 8'h00, 10'd0);

        // random: alternate growing and shrinking phases so the list hits full and empty
        filling    = 1'b1;
        phase_left = $urandom_range(30, 90);
        for (idx = 0; idx < RANDOM_WORDS; idx++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(30, 90);
            end
            phase_left--;

            pick = $urandom_range(0, 99);
            if (filling) begin
                cmd = (pick < 35) ? CMD_ENQ    : (pick < 65) ? CMD_INSERT :
                      (pick < 72) ? CMD_DEQ    : (pick < 79) ? CMD_DELETE :
                      (pick < 89) ? CMD_SEARCH : (pick < 98) ? CMD_READ   :
                      (pick < 99) ? CMD_SPARE_LO : CMD_SPARE_HI;
            end else begin
                cmd = (pick < 8)  ? CMD_ENQ    : (pick < 16) ? CMD_INSERT :
                      (pick < 45) ? CMD_DEQ    : (pick < 70) ? CMD_DELETE :
                      (pick < 85) ? CMD_SEARCH : (pick < 98) ? CMD_READ   :
                      (pick < 99) ? CMD_SPARE_LO : CMD_SPARE_HI;
            end

            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pos = PW'($urandom_range(0, last_count));
            end else if (pick < 90) begin
                pos = PW'($urandom_range(0, DEPTH));
            end else begin
                pos = PW'($urandom_range(0, 31));
            end

            key = ($urandom_range(0, 99) < 60) ? key_pool[$urandom_range(0, 7)] : $urandom;
            avg = ($urandom_range(0, 99) < 95) ? 10'($urandom_range(0, 1000))
                                               : 10'($urandom_range(1001, 1023));
            send_word(cmd, pos, key, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), avg);
        end
        start <= 1'b0;

        // drain outstanding results, then give the block time to misbehave
        @(posedge i_clk);
        while (pending_results != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d command words: enq %0d, deq %0d, insert %0d, delete %0d, %s",
                 words_sent, words_by_cmd[CMD_ENQ], words_by_cmd[CMD_DEQ],
                 words_by_cmd[CMD_INSERT], words_by_cmd[CMD_DELETE],
                 $sformatf("search %0d, read %0d, spare %0d", words_by_cmd[CMD_SEARCH],
                           words_by_cmd[CMD_READ],
                           words_by_cmd[CMD_SPARE_LO] + words_by_cmd[CMD_SPARE_HI]));
        $display("compared %0d result words, %0d field mismatches",
                 checked_results, error_count);
        if (error_count == 0 && pending_results == 0) begin
            $display("positional_record_list: match");
        end else begin
            $display("positional_record_list: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
